// ===== rtl/ppl_pkg.sv =====
// ----------------------------------------------------------------------------
// ppl_pkg
// Shared types, constants and helpers of the palette and luma classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppl_pkg;

  // Channel and palette geometry
  localparam int CHAN_W       = 8;
  localparam int SQ_W         = 2 * CHAN_W;
  localparam int PALETTE_SIZE = 7;
  localparam int PAL_IDX_W    = 3;
  localparam int LUMA_W       = 7;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  // Palette codes
  localparam logic [PAL_IDX_W-1:0] PAL_BLUE    = 3'd0;
  localparam logic [PAL_IDX_W-1:0] PAL_GREEN   = 3'd1;
  localparam logic [PAL_IDX_W-1:0] PAL_CYAN    = 3'd2;
  localparam logic [PAL_IDX_W-1:0] PAL_RED     = 3'd3;
  localparam logic [PAL_IDX_W-1:0] PAL_MAGENTA = 3'd4;
  localparam logic [PAL_IDX_W-1:0] PAL_YELLOW  = 3'd5;
  localparam logic [PAL_IDX_W-1:0] PAL_WHITE   = 3'd6;

  // Channel presence per palette entry: bit 2 red, bit 1 green, bit 0 blue
  localparam logic [2:0] PAL_MASK [PALETTE_SIZE] = '{
    3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7
  };

  // Luma: floor((21R + 71G + 8B) / 300) via reciprocal, exact for sums < 28728
  localparam int LUMA_SUM_W  = 15;
  localparam int LUMA_PROD_W = 30;
  localparam int LUMA_SHIFT  = 23;
  localparam logic [LUMA_SUM_W-1:0] LUMA_WR    = 15'd21;
  localparam logic [LUMA_SUM_W-1:0] LUMA_WG    = 15'd71;
  localparam logic [LUMA_SUM_W-1:0] LUMA_WB    = 15'd8;
  localparam logic [LUMA_SUM_W-1:0] LUMA_RECIP = 15'd27963;
  localparam logic [LUMA_W-1:0]     LUMA_MAX   = 7'd85;

  // Integer square root: sums stay below 2^18, so the walk starts at bit 16
  localparam int SQ_REM_W           = 18;
  localparam int SQ_RES_W           = 19;
  localparam int SQ_TOP_BIT         = 16;
  localparam int SQ_STAGES          = 3;
  localparam int SQ_STEPS_PER_STAGE = 3;
  localparam int DIST_W             = 9;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [PAL_IDX_W-1:0] palette_index;
    logic [LUMA_W-1:0]    luma_index;
  } res_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_RES_W-1:0] res;
  } sqrt_lane_t;

  typedef struct packed {
    logic [DIST_W-1:0]    distance;
    logic [PAL_IDX_W-1:0] idx;
  } cand_t;

  // One digit of the restoring square root
  function automatic sqrt_lane_t sqrt_step(sqrt_lane_t l, logic [SQ_RES_W-1:0] bitv);
    logic [SQ_RES_W:0] trial;
    sqrt_lane_t        n;
    trial = {1'b0, l.res} + {1'b0, bitv};
    if ({{(SQ_RES_W + 1 - SQ_REM_W){1'b0}}, l.rem} >= trial) begin
      n.rem = l.rem - trial[SQ_REM_W-1:0];
      n.res = (l.res >> 1) + bitv;
    end else begin
      n.rem = l.rem;
      n.res = l.res >> 1;
    end
    return n;
  endfunction

  // Keep the left (earlier) candidate unless the right one is strictly closer
  function automatic cand_t pick(cand_t l, cand_t r);
    return (r.distance < l.distance) ? r : l;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ppl_nearest.sv =====
// ----------------------------------------------------------------------------
// ppl_nearest
// Selects the closest palette entry from seven distances, first entry on ties.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppl_nearest (
  input  wire logic [ppl_pkg::DIST_W-1:0]    distance [ppl_pkg::PALETTE_SIZE],
  output logic      [ppl_pkg::PAL_IDX_W-1:0] idx
);

  ppl_pkg::cand_t c   [ppl_pkg::PALETTE_SIZE];
  ppl_pkg::cand_t l1  [4];
  ppl_pkg::cand_t l2  [2];
  ppl_pkg::cand_t win;

  // Tag each distance with its palette code
  always_comb begin
    for (int k = 0; k < ppl_pkg::PALETTE_SIZE; k++) begin
      c[k].distance = distance[k];
      c[k].idx      = ppl_pkg::PAL_IDX_W'(k);
    end
  end

  // Reduce in a tree; the left branch always holds the lower codes
  always_comb begin
    l1[0] = ppl_pkg::pick(c[0], c[1]);
    l1[1] = ppl_pkg::pick(c[2], c[3]);
    l1[2] = ppl_pkg::pick(c[4], c[5]);
    l1[3] = c[6];
    l2[0] = ppl_pkg::pick(l1[0], l1[1]);
    l2[1] = ppl_pkg::pick(l1[2], l1[3]);
    win   = ppl_pkg::pick(l2[0], l2[1]);
  end

  assign idx = win.idx;

endmodule

`default_nettype wire

// ===== rtl/pixel_palette_and_luma_classifier.sv =====
// ----------------------------------------------------------------------------
// pixel_palette_and_luma_classifier
// Maps an RGB pixel to its nearest bright palette color and a luma index.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_data carries one RGB pixel a beat.
//   Output channel out_valid / out_stall / out_data returns one result a beat:
//   the nearest palette code (blue, green, cyan, red, magenta, yellow, white,
//   ties to the earlier code, compared on floored Euclidean distance) and the
//   luma index floor((21R + 71G + 8B) / 300), 0 to 85.
//   One beat enters every cycle while in_stall is low. The six-stage pipeline
//   holds the squares, the sums and luma multiply, three square-root stages
//   of three digits each, and the registered nearest-color tree.
//   Reset clears every stage valid bit; no beat is in flight afterward.
//   When the receiver stalls, the last stage holds its result and bubbles
//   upstream are squeezed out; in_stall rises only once every stage is full.
//   Nothing is dropped or repeated under stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pixel_palette_and_luma_classifier (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ppl_pkg::pix_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ppl_pkg::res_t      out_data
);

  localparam int NSTG = ppl_pkg::SQ_STAGES + 3;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] v_in;

  // Stage 1: channel squares and luma weighted sum
  logic [ppl_pkg::SQ_W-1:0]       sq_lo_r [3];
  logic [ppl_pkg::SQ_W-1:0]       sq_hi_r [3];
  logic [ppl_pkg::SQ_W-1:0]       sq_lo_nxt [3];
  logic [ppl_pkg::SQ_W-1:0]       sq_hi_nxt [3];
  logic [ppl_pkg::LUMA_SUM_W-1:0] lsum_r;
  logic [ppl_pkg::LUMA_SUM_W-1:0] lsum_nxt;

  // Stage 2: distance sums and luma reciprocal product
  ppl_pkg::sqrt_lane_t             sum_r [ppl_pkg::PALETTE_SIZE];
  ppl_pkg::sqrt_lane_t             sum_nxt [ppl_pkg::PALETTE_SIZE];
  logic [ppl_pkg::LUMA_PROD_W-1:0] lprod_r;
  logic [ppl_pkg::LUMA_PROD_W-1:0] lprod_nxt;

  // Stages 3 to 5: square-root digits
  ppl_pkg::sqrt_lane_t        rt_r [ppl_pkg::SQ_STAGES][ppl_pkg::PALETTE_SIZE];
  ppl_pkg::sqrt_lane_t        rt_nxt [ppl_pkg::SQ_STAGES][ppl_pkg::PALETTE_SIZE];
  logic [ppl_pkg::LUMA_W-1:0] lq_r [ppl_pkg::SQ_STAGES];

  // Stage 6: output
  logic [ppl_pkg::DIST_W-1:0]    pal_dist [ppl_pkg::PALETTE_SIZE];
  logic [ppl_pkg::PAL_IDX_W-1:0] near_idx;
  ppl_pkg::res_t                 out_r;

  // Stage handshake: a stage loads when empty or when the next one moves
  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int s = NSTG - 2; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
    v_in[0] = in_valid;
    for (int s = 1; s < NSTG; s++) begin
      v_in[s] = v_r[s-1];
    end
  end

  assign in_stall = !rdy[0];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NSTG; s++) begin
        if (rdy[s]) begin
          v_r[s] <= v_in[s];
        end
      end
    end
  end

  // Square each channel both against zero and against full scale
  always_comb begin
    logic [ppl_pkg::CHAN_W-1:0] ch [3];
    logic [ppl_pkg::CHAN_W-1:0] inv;
    ch[0] = in_data.red;
    ch[1] = in_data.green;
    ch[2] = in_data.blue;
    for (int c = 0; c < 3; c++) begin
      inv          = ppl_pkg::CHAN_MAX - ch[c];
      sq_lo_nxt[c] = ppl_pkg::SQ_W'(ch[c]) * ppl_pkg::SQ_W'(ch[c]);
      sq_hi_nxt[c] = ppl_pkg::SQ_W'(inv) * ppl_pkg::SQ_W'(inv);
    end
    lsum_nxt = ppl_pkg::LUMA_WR * ppl_pkg::LUMA_SUM_W'(in_data.red)
             + ppl_pkg::LUMA_WG * ppl_pkg::LUMA_SUM_W'(in_data.green)
             + ppl_pkg::LUMA_WB * ppl_pkg::LUMA_SUM_W'(in_data.blue);
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && v_in[0]) begin
      sq_lo_r <= sq_lo_nxt;
      sq_hi_r <= sq_hi_nxt;
      lsum_r  <= lsum_nxt;
    end
  end

  // Form squared distance to each palette entry; scale luma by reciprocal
  always_comb begin
    logic [2:0] m;
    for (int k = 0; k < ppl_pkg::PALETTE_SIZE; k++) begin
      m = ppl_pkg::PAL_MASK[k];
      sum_nxt[k].rem = ppl_pkg::SQ_REM_W'(m[2] ? sq_hi_r[0] : sq_lo_r[0])
                     + ppl_pkg::SQ_REM_W'(m[1] ? sq_hi_r[1] : sq_lo_r[1])
                     + ppl_pkg::SQ_REM_W'(m[0] ? sq_hi_r[2] : sq_lo_r[2]);
      sum_nxt[k].res = '0;
    end
    lprod_nxt = ppl_pkg::LUMA_PROD_W'(lsum_r) * ppl_pkg::LUMA_PROD_W'(ppl_pkg::LUMA_RECIP);
  end

  always_ff @(posedge clk) begin
    if (rdy[1] && v_in[1]) begin
      sum_r   <= sum_nxt;
      lprod_r <= lprod_nxt;
    end
  end

  // Run three root digits per stage on every lane
  always_comb begin
    ppl_pkg::sqrt_lane_t l;
    for (int s = 0; s < ppl_pkg::SQ_STAGES; s++) begin
      for (int k = 0; k < ppl_pkg::PALETTE_SIZE; k++) begin
        l = (s == 0) ? sum_r[k] : rt_r[(s == 0) ? 0 : s - 1][k];
        for (int j = 0; j < ppl_pkg::SQ_STEPS_PER_STAGE; j++) begin
          l = ppl_pkg::sqrt_step(l, ppl_pkg::SQ_RES_W'(1) <<
                (ppl_pkg::SQ_TOP_BIT - 2 * (ppl_pkg::SQ_STEPS_PER_STAGE * s + j)));
        end
        rt_nxt[s][k] = l;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < ppl_pkg::SQ_STAGES; s++) begin
      if (rdy[2+s] && v_in[2+s]) begin
        rt_r[s] <= rt_nxt[s];
        if (s == 0) begin
          lq_r[s] <= lprod_r[ppl_pkg::LUMA_SHIFT +: ppl_pkg::LUMA_W];
        end else begin
          lq_r[s] <= lq_r[(s == 0) ? 0 : s - 1];
        end
      end
    end
  end

  // Pick the nearest color from the floored distances
  always_comb begin
    for (int k = 0; k < ppl_pkg::PALETTE_SIZE; k++) begin
      pal_dist[k] = rt_r[ppl_pkg::SQ_STAGES-1][k].res[ppl_pkg::DIST_W-1:0];
    end
  end

  ppl_nearest u_nearest (
    .distance (pal_dist),
    .idx      (near_idx)
  );

  always_ff @(posedge clk) begin
    if (rdy[NSTG-1] && v_in[NSTG-1]) begin
      out_r.palette_index <= near_idx;
      out_r.luma_index    <= lq_r[ppl_pkg::SQ_STAGES-1];
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_pal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.palette_index <= ppl_pkg::PAL_WHITE)
    else $error("palette code beyond white");

  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.luma_index <= ppl_pkg::LUMA_MAX)
    else $error("luma index out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r) && out_stall)
    else $error("input stalled with room in the pipeline");

  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NSTG-1] && out_stall) |=> v_r[NSTG-1] && $stable(out_r))
    else $error("stalled result lost or changed");
`endif

endmodule

`default_nettype wire

// ===== test/pixel_palette_and_luma_classifier_test.sv =====
// ----------------------------------------------------------------------------
// pixel_palette_and_luma_classifier_test
// Drives RGB pixel beats through the classifier under random gaps and output
// stalls, predicts the nearest palette code and luma index of every accepted
// beat, and checks each result beat in order against those predictions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_palette_and_luma_classifier_test;

  localparam int IDLE_LIMIT  = 1000;
  localparam int SETTLE_TAIL = 20;
  localparam int REPORT_MAX  = 10;

  // Expected-result store and palette/luma predictor
  class color_scoreboard;
    ppl_pkg::res_t pending_results[$];
    int unsigned   pixels_noted;
    int unsigned   results_checked;
    int unsigned   mismatches;

    // Largest r with r*r <= v
    function int unsigned floor_root(int unsigned v);
      int unsigned r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
    endfunction

    function ppl_pkg::res_t classify(ppl_pkg::pix_t p);
      ppl_pkg::res_t r;
      logic [2:0]    presence;
      int unsigned   dr, dg, db, distance, best_dist;
      r.palette_index = ppl_pkg::PAL_BLUE;
      best_dist = 0;
      for (int code = ppl_pkg::PAL_BLUE; code <= ppl_pkg::PAL_WHITE; code++) begin
        // code + 1 gives the channels present: bit 2 red, bit 1 green, bit 0 blue
        presence = 3'(code + 1);
        dr = presence[2] ? 32'(ppl_pkg::CHAN_MAX - p.red)   : 32'(p.red);
        dg = presence[1] ? 32'(ppl_pkg::CHAN_MAX - p.green) : 32'(p.green);
        db = presence[0] ? 32'(ppl_pkg::CHAN_MAX - p.blue)  : 32'(p.blue);
        distance = floor_root(dr * dr + dg * dg + db * db);
        // Keep the earlier color unless this one is strictly closer
        if (code == ppl_pkg::PAL_BLUE || distance < best_dist) begin
          best_dist = distance;
          r.palette_index = ppl_pkg::PAL_IDX_W'(code);
        end
      end
      r.luma_index = ppl_pkg::LUMA_W'(((21 * p.red + 71 * p.green + 8 * p.blue) / 100) / 3);
      return r;
    endfunction

    function void note_pixel(ppl_pkg::pix_t p);
      pending_results.push_back(classify(p));
      pixels_noted++;
    endfunction

    function void check_result(ppl_pkg::res_t got);
      ppl_pkg::res_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result beat: palette %0d luma %0d",
                   got.palette_index, got.luma_index);
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (got.palette_index !== want.palette_index || got.luma_index !== want.luma_index) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch on result %0d: palette exp %0d got %0d, luma exp %0d got %0d",
                   results_checked, want.palette_index, got.palette_index,
                   want.luma_index, got.luma_index);
      end
    endfunction
  endclass

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  ppl_pkg::pix_t in_data   = '0;
  logic          out_stall = 1'b0;
  logic          in_stall;
  logic          out_valid;
  ppl_pkg::res_t out_data;

  color_scoreboard sb = new();
  bit              calm_phase = 1'b0;
  int unsigned     idle_cycles = 0;

  pixel_palette_and_luma_classifier uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Note accepted pixel beats, then check accepted result beats
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_pixel(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Stall the result side in random bursts; hold it open in the calm phase
  always @(posedge clk) begin
    int unsigned hold_left;
    if (!rst_n || calm_phase) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      hold_left = $urandom_range(1, 15) - 1;
    end else begin
      out_stall <= 1'b0;
      hold_left = $urandom_range(1, 20) - 1;
    end
  end

  // Abort when no beat moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, sb.pending_results.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // Offer one pixel beat, with an optional random gap ahead of it
  task automatic send_pixel(input ppl_pkg::pix_t p);
    int unsigned gap;
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic send_rgb(input int unsigned r, input int unsigned g, input int unsigned b);
    ppl_pkg::pix_t p;
    p.red   = 8'(r);
    p.green = 8'(g);
    p.blue  = 8'(b);
    send_pixel(p);
  endtask

  // Hold the input idle until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_channel();
    logic [7:0] corners [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    if ($urandom_range(0, 4) == 0) return corners[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random(input int unsigned count);
    ppl_pkg::pix_t p;
    repeat (count) begin
      p.red   = random_channel();
      p.green = random_channel();
      p.blue  = random_channel();
      send_pixel(p);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pure palette colors, black with its three-way tie, grays, near-ties
    send_rgb(0, 0, 255);
    send_rgb(0, 255, 0);
    send_rgb(0, 255, 255);
    send_rgb(255, 0, 0);
    send_rgb(255, 0, 255);
    send_rgb(255, 255, 0);
    send_rgb(255, 255, 255);
    send_rgb(0, 0, 0);
    send_rgb(1, 0, 0);
    send_rgb(0, 1, 0);
    send_rgb(0, 0, 1);
    send_rgb(127, 127, 127);
    send_rgb(128, 128, 128);
    send_rgb(0, 255, 127);
    send_rgb(0, 255, 128);
    send_rgb(127, 0, 128);
    send_rgb(128, 128, 0);
    // Luma steps around the first and last boundaries
    send_rgb(0, 4, 1);
    send_rgb(0, 4, 2);
    send_rgb(255, 255, 254);
    send_rgb(254, 255, 255);
    send_rgb(170, 85, 42);
    drain_results();

    send_random(800);
    drain_results();
    send_random(800);

    // Finish with back-to-back beats and no stalls
    calm_phase = 1'b1;
    send_random(300);
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TAIL) @(posedge clk);

    $display("summary: %0d pixels sent, %0d results checked, %0d mismatches, %0d left over",
             sb.pixels_noted, sb.results_checked, sb.mismatches, sb.pending_results.size());
    $display("summary: palette extremes, ties, luma edges and random pixels under gaps and stalls");
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ppl_pkg.sv
rtl/ppl_nearest.sv
rtl/pixel_palette_and_luma_classifier.sv
test/pixel_palette_and_luma_classifier_test.sv
